[rtl/multiplexed_seven_segment_driver_assert.svh]
// Assertion macros for the multiplexed seven-segment driver checker.
// Both macros sample on the rising edge of clock; they rely on the including
// scope having signals named clock and reset.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_DRIVER_ASSERT_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_DRIVER_ASSERT_SVH

// Property checked only outside reset.
`define MSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property checked on every edge, reset included.
`define MSD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

[rtl/msd_pkg.sv]
// Shared types, constants and the segment decode table for the
// multiplexed seven-segment driver. No dependencies.
`default_nettype none

package msd_pkg;

   localparam int NUM_DIGITS = 6;
   localparam int GROUP_SIZE = 3;
   localparam int POS_W      = $clog2(NUM_DIGITS);

   typedef logic [3:0]            digit_type;
   typedef logic [POS_W-1:0]      pos_type;
   typedef logic [7:0]            seg_type;
   typedef logic [NUM_DIGITS-1:0] enable_type;
   typedef logic [15:0]           value_type;

   localparam logic      OP_WRITE      = 1'b0;
   localparam logic      OP_TICK       = 1'b1;
   localparam logic      GROUP_LOWER   = 1'b0;
   localparam value_type MAX_SHOWN     = value_type'(999);
   localparam seg_type   BLANK_PATTERN = 8'hFF;

   typedef struct packed {
      digit_type hundreds;
      digit_type tens;
      digit_type units;
   } digits_type;

   typedef struct packed {
      logic write_en;
      logic tick_en;
      logic group;
   } core_ctrl_type;

   typedef struct packed {
      seg_type    segments;
      enable_type digit_enable;
   } scan_out_type;

   // Active-low pattern, decimal point off, segments g..a in bits 6..0.
   function automatic seg_type seg_pattern(input digit_type digit);
      seg_type pattern;
      unique case (digit)
         4'd0:    pattern = 8'hC0;
         4'd1:    pattern = 8'hF9;
         4'd2:    pattern = 8'hA4;
         4'd3:    pattern = 8'hB0;
         4'd4:    pattern = 8'h99;
         4'd5:    pattern = 8'h92;
         4'd6:    pattern = 8'h82;
         4'd7:    pattern = 8'hF8;
         4'd8:    pattern = 8'h80;
         4'd9:    pattern = 8'h90;
         default: pattern = BLANK_PATTERN;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

[rtl/msd_digit_split.sv]
// Saturates a write value at 999 and splits it into decimal digits.
// Depends on msd_pkg.
`default_nettype none

module msd_digit_split (
   input  msd_pkg::value_type  value,
   output msd_pkg::digits_type digits
);
   import msd_pkg::*;

   logic [9:0] sat;
   digit_type  hundreds;
   logic [9:0] hundreds_x100;
   logic [6:0] rem;
   digit_type  tens;
   logic [6:0] tens_x10;

   // Digits come from parallel threshold compares; the products are shift-adds.
   always_comb begin
      sat = (value > MAX_SHOWN) ? MAX_SHOWN[9:0] : value[9:0];

      hundreds = '0;
      for (int k = 1; k <= 9; k++) begin
         hundreds = hundreds + digit_type'(sat >= 10'(k * 100));
      end
      hundreds_x100 = (10'(hundreds) << 6) + (10'(hundreds) << 5) + (10'(hundreds) << 2);
      rem = 7'(sat - hundreds_x100);

      tens = '0;
      for (int k = 1; k <= 9; k++) begin
         tens = tens + digit_type'(rem >= 7'(k * 10));
      end
      tens_x10 = (7'(tens) << 3) + (7'(tens) << 1);

      digits.hundreds = hundreds;
      digits.tens     = tens;
      digits.units    = 4'(rem - tens_x10);
   end

endmodule

`default_nettype wire

[rtl/msd_display_core.sv]
// Digit store and scan counter: takes digit writes and produces the segment
// pattern and digit enable for each scan tick. Depends on msd_pkg.
`default_nettype none

module msd_display_core (
   input  logic                  clock,
   input  logic                  reset,
   input  msd_pkg::core_ctrl_type ctrl,
   input  msd_pkg::digits_type   digits,
   output msd_pkg::scan_out_type scan_out
);
   import msd_pkg::*;

   digit_type digit_ff [NUM_DIGITS];
   digit_type digit_in [NUM_DIGITS];
   pos_type   scan_pos_ff;
   pos_type   scan_pos_in;
   pos_type   read_pos;

   // An out-of-range scan position is read as position zero.
   always_comb begin
      read_pos = (scan_pos_ff >= pos_type'(NUM_DIGITS)) ? '0 : scan_pos_ff;
      scan_out.segments     = seg_pattern(digit_ff[read_pos]);
      scan_out.digit_enable = enable_type'(1'b1) << read_pos;
      if (ctrl.tick_en) begin
         scan_pos_in = (read_pos == pos_type'(NUM_DIGITS - 1)) ? '0 : read_pos + 1'b1;
      end else begin
         scan_pos_in = scan_pos_ff;
      end
   end

   // The lower group holds positions 0..2 and the upper group 3..5,
   // hundreds first in each.
   always_comb begin
      for (int i = 0; i < NUM_DIGITS; i++) begin
         digit_in[i] = digit_ff[i];
         if (ctrl.write_en && ((i >= GROUP_SIZE) == ctrl.group)) begin
            unique case (i % GROUP_SIZE)
               0:       digit_in[i] = digits.hundreds;
               1:       digit_in[i] = digits.tens;
               default: digit_in[i] = digits.units;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pos_ff <= '0;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_ff[i] <= '0;
         end
      end else begin
         scan_pos_ff <= scan_pos_in;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            digit_ff[i] <= digit_in[i];
         end
      end
   end

endmodule

`default_nettype wire

[rtl/msd_result_reg.sv]
// Result register of the rsp channel: holds one beat until the receiver
// takes it, and reloads in the same cycle it is taken. Depends on msd_pkg.
`default_nettype none

module msd_result_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  load,
   input  msd_pkg::scan_out_type load_data,
   output logic                  free,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output msd_pkg::seg_type      rsp_segments,
   output msd_pkg::enable_type   rsp_digit_enable
);
   import msd_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   scan_out_type data_ff;

   assign free     = !valid_ff || !rsp_stall;
   assign valid_in = load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_segments     = data_ff.segments;
   assign rsp_digit_enable = data_ff.digit_enable;

endmodule

`default_nettype wire

[rtl/multiplexed_seven_segment_driver.sv]
// Six-digit multiplexed seven-segment driver. A req beat with op = write
// saturates value at 999 and stores its three decimal digits in the lower
// (group 0, digits 0..2) or upper (group 1, digits 3..5) group; it gives no
// rsp beat. A req beat with op = tick gives one rsp beat: the active-low
// pattern of the digit at the scan position (point off, blank for a non-digit)
// with its one-hot enable, and then steps the scan position, wrapping after
// digit 5. One req beat is accepted per cycle while req_stall is low. A tick
// passes the input register and then the result register, which offers its
// rsp beat. The only back-pressure is a tick waiting in the input register
// while the result register holds a stalled beat; writes always drain. Reset
// clears all digits to zero and the scan position to digit 0.
// Depends on msd_pkg, msd_digit_split, msd_display_core, msd_result_reg.
`default_nettype none

module multiplexed_seven_segment_driver (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic                req_op,
   input  msd_pkg::value_type  req_value,
   input  logic                req_group,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output msd_pkg::seg_type    rsp_segments,
   output msd_pkg::enable_type rsp_digit_enable
);
   import msd_pkg::*;

   logic          s1_valid_ff;
   logic          s1_valid_in;
   logic          s1_op_ff;
   value_type     s1_value_ff;
   logic          s1_group_ff;
   logic          s1_is_tick;
   logic          s1_fire;
   logic          req_accept;
   logic          out_free;
   core_ctrl_type ctrl;
   digits_type    digits;
   scan_out_type  scan_out;

   assign s1_is_tick  = (s1_op_ff == OP_TICK);
   assign s1_fire     = s1_valid_ff && (!s1_is_tick || out_free);
   assign req_stall   = s1_valid_ff && !s1_fire;
   assign req_accept  = req_valid && !req_stall;
   assign s1_valid_in = req_accept || (s1_valid_ff && !s1_fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_op_ff    <= req_op;
         s1_value_ff <= req_value;
         s1_group_ff <= req_group;
      end
   end

   always_comb begin
      ctrl.write_en = s1_fire && !s1_is_tick;
      ctrl.tick_en  = s1_fire && s1_is_tick;
      ctrl.group    = (s1_group_ff != GROUP_LOWER);
   end

   msd_digit_split u_split (
      .value  (s1_value_ff),
      .digits (digits)
   );

   msd_display_core u_core (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .digits   (digits),
      .scan_out (scan_out)
   );

   msd_result_reg u_result (
      .clock            (clock),
      .reset            (reset),
      .load             (ctrl.tick_en),
      .load_data        (scan_out),
      .free             (out_free),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_segments     (rsp_segments),
      .rsp_digit_enable (rsp_digit_enable)
   );

endmodule

`default_nettype wire

[rtl/msd_checker.sv]
// Port-level checker for the multiplexed seven-segment driver, bound to the
// top level. Depends on msd_pkg and multiplexed_seven_segment_driver_assert.svh.
`default_nettype none

`include "multiplexed_seven_segment_driver_assert.svh"

module msd_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input msd_pkg::seg_type    rsp_segments,
   input msd_pkg::enable_type rsp_digit_enable
);
   import msd_pkg::*;

   // Enable expected on the next rsp beat; the scan walks the digits in order.
   enable_type exp_en_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_en_ff <= enable_type'(1'b1);
      end else if (rsp_valid && !rsp_stall) begin
         exp_en_ff <= {exp_en_ff[NUM_DIGITS-2:0], exp_en_ff[NUM_DIGITS-1]};
      end
   end

   `MSD_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_segments) && $stable(rsp_digit_enable), "stalled rsp beat changed")
   `MSD_ASSERT(a_scan_order, rsp_valid |-> rsp_digit_enable == exp_en_ff, "rsp beat drives the wrong digit")
   `MSD_ASSERT(a_point_off, rsp_valid |-> rsp_segments[7], "decimal point driven on")
   `MSD_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "rsp beat present after reset")

endmodule

bind multiplexed_seven_segment_driver msd_checker u_msd_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_segments     (rsp_segments),
   .rsp_digit_enable (rsp_digit_enable)
);

`default_nettype wire

[bench/multiplexed_seven_segment_driver_test.sv]
// Self-checking bench for the multiplexed seven-segment driver: random write and scan
// beats against a digit-store predictor, with stalls on both channels.
// Depends on msd_pkg and the multiplexed_seven_segment_driver RTL.
module multiplexed_seven_segment_driver_test;
   import msd_pkg::*;

   localparam logic GROUP_UPPER  = 1'b1;
   localparam int   IDLE_PCT     = 19;
   localparam int   HOLD_CYCLES  = 90;
   localparam int   SETTLE       = 12;
   localparam int   LIMIT_CYCLES = 200000;
   localparam int   PHASE_ITEMS  = 300;

   typedef struct packed {
      logic      op;
      value_type value;
      logic      group;
   } panel_req_type;

   typedef struct packed {
      seg_type    segments;
      enable_type digit_enable;
   } scan_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_op = OP_WRITE;
   value_type  req_value = '0;
   logic       req_group = GROUP_LOWER;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   seg_type    rsp_segments;
   enable_type rsp_digit_enable;

   panel_req_type req_queue[$];
   scan_beat_type pending_scans[$];
   digit_type     shown_digits [NUM_DIGITS];
   pos_type       scan_pos = '0;

   logic steady_phase = 1'b0;
   logic hold_armed = 1'b0;
   logic hold_done;
   int   hold_left;
   int   mismatch_count = 0;
   int   writes_taken = 0;
   int   scans_taken = 0;
   int   scans_checked = 0;
   int   cycle_count = 0;

   multiplexed_seven_segment_driver dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_value(req_value),
      .req_group(req_group),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_segments(rsp_segments),
      .rsp_digit_enable(rsp_digit_enable)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic seg_type glyph_for(input digit_type digit);
      case (digit)
         4'd0: return 8'hC0;
         4'd1: return 8'hF9;
         4'd2: return 8'hA4;
         4'd3: return 8'hB0;
         4'd4: return 8'h99;
         4'd5: return 8'h92;
         4'd6: return 8'h82;
         4'd7: return 8'hF8;
         4'd8: return 8'h80;
         4'd9: return 8'h90;
         default: return 8'hFF;
      endcase
   endfunction

   // Applies one accepted request beat to the shadow display and queues the scan
   // beat that a tick is due to produce.
   task automatic advance_display(input logic op, input value_type value, input logic group);
      value_type     shown;
      int            base;
      scan_beat_type beat;
      if (op == OP_WRITE) begin
         shown = (value > MAX_SHOWN) ? MAX_SHOWN : value;
         base = (group == GROUP_UPPER) ? GROUP_SIZE : 0;
         shown_digits[base] = digit_type'(shown / 100);
         shown_digits[base + 1] = digit_type'((shown / 10) % 10);
         shown_digits[base + 2] = digit_type'(shown % 10);
         writes_taken++;
      end else begin
         beat.segments = glyph_for(shown_digits[scan_pos]);
         beat.digit_enable = enable_type'(1) << scan_pos;
         pending_scans.push_back(beat);
         scan_pos = (scan_pos >= NUM_DIGITS - 1) ? '0 : scan_pos + 1'b1;
         scans_taken++;
      end
   endtask

   // Request driver: a stalled beat is held unchanged, otherwise the next beat
   // is offered unless this cycle is picked as a gap.
   always @(posedge clock) begin : drive_req
      panel_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) advance_display(req_op, req_value, req_group);
         if (req_queue.size() != 0 && (steady_phase || $urandom_range(0, 99) >= IDLE_PCT)) begin
            next_req = req_queue.pop_front();
            req_valid <= 1'b1;
            req_op <= next_req.op;
            req_value <= next_req.value;
            req_group <= next_req.group;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result stall: random gaps, none in the steady phase, and one long hold-off
   // once armed so that the block backs up into its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_armed && !hold_done) begin
         hold_left <= HOLD_CYCLES - 1;
         hold_done <= 1'b1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !steady_phase && ($urandom_range(0, 99) < IDLE_PCT);
      end
   end

   always @(posedge clock) begin : check_scan
      scan_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_scans.size() == 0) begin
            $error("scan beat with nothing expected: segments %h, digit_enable %b",
                   rsp_segments, rsp_digit_enable);
            mismatch_count++;
         end else begin
            want = pending_scans.pop_front();
            if (rsp_segments !== want.segments) begin
               $error("segments: expected %h, got %h", want.segments, rsp_segments);
               mismatch_count++;
            end
            if (rsp_digit_enable !== want.digit_enable) begin
               $error("digit_enable: expected %b, got %b", want.digit_enable, rsp_digit_enable);
               mismatch_count++;
            end
            scans_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles", cycle_count);
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic queue_write(input value_type value, input logic group);
      panel_req_type item;
      item.op = OP_WRITE;
      item.value = value;
      item.group = group;
      req_queue.push_back(item);
   endtask

   task automatic queue_tick();
      panel_req_type item;
      item.op = OP_TICK;
      item.value = value_type'($urandom);
      item.group = 1'($urandom_range(0, 1));
      req_queue.push_back(item);
   endtask

   function automatic value_type pick_value();
      case ($urandom_range(0, 4))
         0: return value_type'($urandom_range(0, 999));
         1: return value_type'($urandom_range(1000, 65535));
         2: return value_type'($urandom_range(0, 15));
         3: return value_type'($urandom);
         default: begin
            case ($urandom_range(0, 3))
               0: return 16'd0;
               1: return 16'd999;
               2: return 16'd1000;
               default: return 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 55) queue_tick();
         else queue_write(pick_value(), 1'($urandom_range(0, 1)));
      end
   endtask

   // Lets the bench run dry: nothing left to send and no scan beat outstanding.
   task automatic wait_drained();
      do @(negedge clock);
      while (req_queue.size() != 0 || req_valid || pending_scans.size() != 0);
   endtask

   initial begin
      for (int i = 0; i < NUM_DIGITS; i++) shown_digits[i] = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // All-zero display after reset, then every digit, saturation and the wrap.
      repeat (6) queue_tick();
      queue_write(16'd123, GROUP_LOWER);
      queue_write(16'd456, GROUP_UPPER);
      repeat (6) queue_tick();
      queue_write(16'd789, GROUP_LOWER);
      queue_write(16'hFFFF, GROUP_UPPER);
      repeat (4) queue_tick();
      queue_write(16'd1000, GROUP_UPPER);
      queue_write(16'd0, GROUP_LOWER);
      repeat (3) queue_tick();
      wait_drained();

      queue_random(PHASE_ITEMS);
      wait_drained();

      steady_phase = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_drained();
      steady_phase = 1'b0;

      hold_armed = 1'b1;
      queue_random(PHASE_ITEMS);
      wait_drained();

      repeat (SETTLE) @(posedge clock);
      if (pending_scans.size() != 0) begin
         $error("%0d scan beats never arrived", pending_scans.size());
         mismatch_count++;
      end
      $display("Run covered %0d writes and %0d scan ticks (%0d scan beats checked),",
               writes_taken, scans_taken, scans_checked);
      $display("with random stalls on both sides, a gap-free stretch and a long result hold.");
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/msd_pkg.sv
rtl/msd_digit_split.sv
rtl/msd_display_core.sv
rtl/msd_result_reg.sv
rtl/multiplexed_seven_segment_driver.sv
rtl/msd_checker.sv
bench/multiplexed_seven_segment_driver_test.sv
